/* rtl/tpd_pkg.sv */
// Shared types, constants and helpers of the tree path distance block.
`default_nettype none

package tpd_pkg;

    localparam int MAX_NODES = 512;
    localparam int NODE_W    = 9;
    localparam int DIST_W    = 10;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int EPOCH_W   = 8;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] WALK_A_BIT = 2'b01;
    localparam logic [1:0] WALK_B_BIT = 2'b10;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] entry_index;
        logic [NODE_W-1:0] entry_parent;
        logic              entry_is_root;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
    } result_t;

    typedef struct packed {
        logic              is_root;
        logic [NODE_W-1:0] parent;
    } parent_entry_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [1:0]         walk_bits;
        logic [NODE_W-1:0]  depth;
    } mark_entry_t;

    typedef struct packed {
        logic clear_step;
        logic load_entry;
        logic start_query;
        logic init_a;
        logic init_b;
        logic par_rd;
        logic mark_rd;
        logic step_commit;
        logic no_step;
        logic switch_walk;
        logic res_set;
        logic res_found;
        logic res_use_sum;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic same_node;
        logic out_of_range;
        logic epoch_full;
        logic has_parent;
        logic marked;
        logic self_hit;
        logic walk_b;
        logic moved_a;
    } status_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [NODE_W-1:0] n);
        return ADDR_W'(n);
    endfunction

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        return int'(n) < MAX_NODES;
    endfunction

endpackage

`default_nettype wire

/* rtl/tree_path_distance.sv */
// Top level of the tree path distance block: controller plus datapath.
//
// Edge distance between two nodes of a rooted tree held as a parent table.
// An item is taken when start is high and busy is low; the result appears
// for one cycle with done high and cannot be held off, so capture it then.
// A load item (mode 0) writes one parent entry as it is taken and gives
// no result. A query with identical or out-of-range nodes presents its
// result in the cycle right after the transfer. Otherwise the INIT_A and
// INIT_B states mark the start nodes, and each walk step then passes the
// parent table read, the mark memory read and the check and mark, one
// step of walk A and one of walk B per round; a walk at a root only reads
// the parent table before the other walk takes its turn. After reset, and
// after every 255 queries that walk, busy stays high for a pass that
// clears all 512 entries of the visit mark memory.
`default_nettype none

module tree_path_distance (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tpd_pkg::item_t    item,
    output logic                   busy,
    output logic                   done,
    output tpd_pkg::result_t       result
);

    tpd_pkg::cmd_t    cmd;
    tpd_pkg::status_t status;

    tpd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tpd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

/* rtl/tpd_datapath.sv */
// Datapath: parent table, visit mark memory, walk registers and result registers.
`default_nettype none

module tpd_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tpd_pkg::item_t   item,
    input  wire tpd_pkg::cmd_t    cmd,
    output tpd_pkg::status_t      status,
    output tpd_pkg::result_t      result
);

    tpd_pkg::parent_entry_t parent_mem [tpd_pkg::MAX_NODES];
    tpd_pkg::mark_entry_t   mark_mem   [tpd_pkg::MAX_NODES];

    tpd_pkg::parent_entry_t par_q_reg;
    tpd_pkg::mark_entry_t   mark_q_reg;

    logic [tpd_pkg::NODE_W-1:0]  pos_a_reg, pos_b_reg;
    logic [tpd_pkg::NODE_W-1:0]  dep_a_reg, dep_b_reg;
    logic                        walk_b_reg, walk_b_next;
    logic                        moved_a_reg, moved_a_next;
    logic [tpd_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [tpd_pkg::ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [tpd_pkg::DIST_W-1:0]  distance_reg;
    logic                        found_reg;

    logic [tpd_pkg::NODE_W-1:0]  cur_pos;
    logic [tpd_pkg::NODE_W-1:0]  cur_dep;
    logic [tpd_pkg::NODE_W-1:0]  next_dep;
    logic [1:0]                  self_bit;
    logic [tpd_pkg::DIST_W-1:0]  dist_sum;
    logic                        clear_last;

    assign cur_pos    = walk_b_reg ? pos_b_reg : pos_a_reg;
    assign cur_dep    = walk_b_reg ? dep_b_reg : dep_a_reg;
    assign next_dep   = cur_dep + 1'b1;
    assign self_bit   = walk_b_reg ? tpd_pkg::WALK_B_BIT : tpd_pkg::WALK_A_BIT;
    assign dist_sum   = tpd_pkg::DIST_W'(next_dep) + tpd_pkg::DIST_W'(mark_q_reg.depth);
    assign clear_last = (clr_cnt_reg == tpd_pkg::ADDR_W'(tpd_pkg::MAX_NODES - 1));

    always_comb
    begin
        status.clear_last   = clear_last;
        status.same_node    = (item.node_a == item.node_b);
        status.out_of_range = !tpd_pkg::in_range(item.node_a)
                              || !tpd_pkg::in_range(item.node_b);
        status.epoch_full   = (epoch_reg == {tpd_pkg::EPOCH_W{1'b1}});
        status.has_parent   = !par_q_reg.is_root && tpd_pkg::in_range(par_q_reg.parent);
        status.marked       = (mark_q_reg.epoch == epoch_reg) && (mark_q_reg.walk_bits != 2'b00);
        status.self_hit     = |(mark_q_reg.walk_bits & self_bit);
        status.walk_b       = walk_b_reg;
        status.moved_a      = moved_a_reg;
    end

    assign result.distance = distance_reg;
    assign result.found    = found_reg;

    always_comb
    begin
        walk_b_next  = walk_b_reg;
        moved_a_next = moved_a_reg;
        epoch_next   = epoch_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_step)
        begin
            clr_cnt_next = clear_last ? '0 : clr_cnt_reg + 1'b1;
            if (clear_last)
                epoch_next = '0;
        end
        if (cmd.start_query)
        begin
            epoch_next   = epoch_reg + 1'b1;
            walk_b_next  = 1'b0;
            moved_a_next = 1'b0;
        end
        if (cmd.step_commit && !walk_b_reg)
            moved_a_next = 1'b1;
        if (cmd.no_step && !walk_b_reg)
            moved_a_next = 1'b0;
        if (cmd.switch_walk)
            walk_b_next = !walk_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_b_reg  <= 1'b0;
            moved_a_reg <= 1'b0;
            epoch_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            walk_b_reg  <= walk_b_next;
            moved_a_reg <= moved_a_next;
            epoch_reg   <= epoch_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Walk positions and depths.
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            pos_a_reg <= item.node_a;
            pos_b_reg <= item.node_b;
            dep_a_reg <= '0;
            dep_b_reg <= '0;
        end
        else if (cmd.step_commit)
        begin
            if (walk_b_reg)
            begin
                pos_b_reg <= par_q_reg.parent;
                dep_b_reg <= next_dep;
            end
            else
            begin
                pos_a_reg <= par_q_reg.parent;
                dep_a_reg <= next_dep;
            end
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            found_reg    <= cmd.res_found;
            distance_reg <= cmd.res_use_sum ? dist_sum : '0;
        end
    end

    // Parent table.
    always_ff @(posedge clk)
    begin
        if (cmd.load_entry && tpd_pkg::in_range(item.entry_index))
            parent_mem[tpd_pkg::to_addr(item.entry_index)] <=
                '{is_root: item.entry_is_root, parent: item.entry_parent};
        if (cmd.par_rd)
            par_q_reg <= parent_mem[tpd_pkg::to_addr(cur_pos)];
    end

    // Visit marks, tagged with the query epoch so a stale mark reads as unmarked.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mark_mem[clr_cnt_reg] <= '0;
        else if (cmd.init_a)
            mark_mem[tpd_pkg::to_addr(pos_a_reg)] <=
                '{epoch: epoch_reg, walk_bits: tpd_pkg::WALK_A_BIT, depth: '0};
        else if (cmd.init_b)
            mark_mem[tpd_pkg::to_addr(pos_b_reg)] <=
                '{epoch: epoch_reg, walk_bits: tpd_pkg::WALK_B_BIT, depth: '0};
        else if (cmd.step_commit)
            mark_mem[tpd_pkg::to_addr(par_q_reg.parent)] <=
                '{epoch: epoch_reg, walk_bits: self_bit, depth: next_dep};
        if (cmd.mark_rd)
            mark_q_reg <= mark_mem[tpd_pkg::to_addr(par_q_reg.parent)];
    end

endmodule

`default_nettype wire

/* rtl/tpd_ctrl.sv */
// Controller: sequences loads, mark clearing and the alternating ancestor walks.
`default_nettype none

module tpd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              mode,
    input  wire tpd_pkg::status_t  status,
    output tpd_pkg::cmd_t          cmd,
    output logic                   busy,
    output logic                   done
);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_INIT_A  = 8'b0000_0100,
        ST_INIT_B  = 8'b0000_1000,
        ST_RD_PAR  = 8'b0001_0000,
        ST_RD_MARK = 8'b0010_0000,
        ST_CHECK   = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == tpd_pkg::MODE_LOAD)
                        cmd.load_entry = 1'b1;
                    else if (status.same_node)
                    begin
                        cmd.res_set   = 1'b1;
                        cmd.res_found = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else if (status.out_of_range)
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_INIT_A;
                    end
                end
            end
            ST_INIT_A:
            begin
                cmd.init_a = 1'b1;
                state_next = ST_INIT_B;
            end
            ST_INIT_B:
            begin
                cmd.init_b = 1'b1;
                state_next = ST_RD_PAR;
            end
            ST_RD_PAR:
            begin
                cmd.par_rd = 1'b1;
                state_next = ST_RD_MARK;
            end
            ST_RD_MARK:
            begin
                if (status.has_parent)
                begin
                    cmd.mark_rd = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    cmd.no_step = 1'b1;
                    // Drop out when neither walk moved in this round.
                    if (status.walk_b && !status.moved_a)
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.switch_walk = 1'b1;
                        state_next      = ST_RD_PAR;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.marked)
                begin
                    cmd.res_set     = 1'b1;
                    cmd.res_found   = !status.self_hit;
                    cmd.res_use_sum = !status.self_hit;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.step_commit = 1'b1;
                    cmd.switch_walk = 1'b1;
                    state_next      = ST_RD_PAR;
                end
            end
            ST_DONE:
            begin
                state_next = status.epoch_full ? ST_CLEAR : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Testbench for tree_path_distance: parent table loads, distance queries, each result checked as done rises.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpd_pkg::*;

    localparam logic CHECK_TYPED = 1'b1;
    localparam logic CHECK_MODEL = 1'b0;
    localparam int   N_ROWS      = 25;
    localparam int   N_PHASES    = 3;
    localparam int   PHASE_ITEMS = 275;
    localparam int   END_LIMIT   = 20000;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] index;
        logic [NODE_W-1:0] parent;
        logic              is_root;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic              typed;
        logic [DIST_W-1:0] exp_dist;
        logic              found;
    } stim_row_t;

    // Small tree 0..5 plus 511 under 4, a second tree 6-7, a self loop at 510.
    // Then node 0 gets a parent to close a cycle, and is made a root again.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{MODE_LOAD,  9'd0,   9'd0,   1'b1, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd1,   9'd0,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd2,   9'd0,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd3,   9'd1,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd4,   9'd3,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd5,   9'd2,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd6,   9'd511, 1'b1, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd7,   9'd6,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd511, 9'd4,   1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd510, 9'd510, 1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd0,   9'd0,   CHECK_TYPED, 10'd0, 1'b1},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd511, 9'd511, CHECK_TYPED, 10'd0, 1'b1},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd3,   9'd4,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd4,   9'd3,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd511, 9'd5,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd0,   9'd511, CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd7,   9'd511, CHECK_TYPED, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd6,   9'd7,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd510, 9'd0,   CHECK_TYPED, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd0,   9'd511, 1'b0, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd2,   9'd5,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd3,   9'd7,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_LOAD,  9'd0,   9'd0,   1'b1, 9'd0,   9'd0,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd1,   9'd2,   CHECK_MODEL, 10'd0, 1'b0},
        '{MODE_QUERY, 9'd0,   9'd0,   1'b0, 9'd511, 9'd7,   CHECK_MODEL, 10'd0, 1'b0}
    };

    localparam int PHASE_IDLE_PCT [N_PHASES] = '{0, 62, 17};

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    parent_entry_t parent_tbl [MAX_NODES];
    bit            written    [MAX_NODES];
    result_t       pending_dist [$];
    int            errors   = 0;
    int            next_new = 0;
    int            idle_pct = 0;

    tree_path_distance dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(200_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic note_error(input string what);
        errors++;
        if (errors <= 10)
            $display("%s", what);
    endtask

    // Alternate one step of each upward walk until they meet, get stuck or loop.
    // hits_unwritten flags a walk that would read a never-loaded entry.
    function automatic result_t tree_distance(input logic [NODE_W-1:0] na,
                                              input logic [NODE_W-1:0] nb,
                                              output bit hits_unwritten);
        logic [1:0]        mark  [MAX_NODES];
        logic [NODE_W-1:0] depth [MAX_NODES];
        logic [NODE_W-1:0] pos   [2];
        logic [NODE_W-1:0] dpt   [2];
        bit                moved [2];
        logic [1:0]        self_bit;
        logic [NODE_W-1:0] np;
        logic [NODE_W-1:0] nd;
        result_t           r;
        int                w;
        r = '0;
        hits_unwritten = 1'b0;
        if (na == nb)
        begin
            r.found = 1'b1;
            return r;
        end
        if (int'(na) >= MAX_NODES || int'(nb) >= MAX_NODES)
            return r;
        foreach (mark[i])
            mark[i] = 2'b00;
        mark[na]  = WALK_A_BIT;
        depth[na] = '0;
        mark[nb]  = WALK_B_BIT;
        depth[nb] = '0;
        pos[0] = na;
        pos[1] = nb;
        dpt[0] = '0;
        dpt[1] = '0;
        for (int guard = 0; guard <= 2 * MAX_NODES; guard++)
        begin
            for (w = 0; w < 2; w++)
            begin
                self_bit = (w == 0) ? WALK_A_BIT : WALK_B_BIT;
                moved[w] = 1'b0;
                if (!written[pos[w]])
                    hits_unwritten = 1'b1;
                if (!parent_tbl[pos[w]].is_root && int'(parent_tbl[pos[w]].parent) < MAX_NODES)
                begin
                    moved[w] = 1'b1;
                    np = parent_tbl[pos[w]].parent;
                    nd = dpt[w] + 1'b1;
                    if (mark[np] != 2'b00)
                    begin
                        // own mark means a loop in the table
                        if ((mark[np] & self_bit) != 2'b00)
                            return r;
                        r.distance = DIST_W'(nd) + DIST_W'(depth[np]);
                        r.found    = 1'b1;
                        return r;
                    end
                    mark[np]  = self_bit;
                    depth[np] = nd;
                    pos[w]    = np;
                    dpt[w]    = nd;
                end
            end
            if (!moved[0] && !moved[1])
                return r;
        end
        return r;
    endfunction

    task automatic apply_item(input item_t it, input logic typed, input result_t typed_res);
        result_t r;
        bit      miss;
        if (it.mode == MODE_LOAD)
        begin
            if (int'(it.entry_index) < MAX_NODES)
            begin
                parent_tbl[it.entry_index] = '{is_root: it.entry_is_root,
                                               parent: it.entry_parent};
                written[it.entry_index] = 1'b1;
            end
        end
        else
        begin
            r = tree_distance(it.node_a, it.node_b, miss);
            pending_dist.insert(pending_dist.size(), typed ? typed_res : r);
        end
    endtask

    // Hold start until the transfer; an idle gap may come first.
    task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        apply_item(it, typed, typed_res);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_dist.size() != 0);
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        if (next_new > 1 && $urandom_range(0, 99) < 85)
            return NODE_W'($urandom_range(0, next_new - 1));
        return NODE_W'($urandom_range(0, MAX_NODES - 1));
    endfunction

    // Mostly grow the tree one new node at a time under a nearby lower node;
    // some rewrites, some noise that can close loops, some roots.
    function automatic item_t random_load();
        item_t       it;
        logic [63:0] raw;
        int          sel;
        int          idx;
        int          span;
        raw = {$urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.mode = MODE_LOAD;
        sel = $urandom_range(0, 99);
        if (sel < 55 && next_new < MAX_NODES)
        begin
            idx = next_new;
            next_new++;
        end
        else
            idx = $urandom_range(1, MAX_NODES - 1);
        it.entry_index = NODE_W'(idx);
        span = (idx < 12) ? idx : 12;
        if (sel >= 92)
            it.entry_is_root = 1'b1;
        else if (sel >= 80)
            it.entry_is_root = 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 99) < 4)
            it.entry_is_root = 1'b1;
        else
        begin
            it.entry_is_root = 1'b0;
            it.entry_parent  = NODE_W'(idx - $urandom_range(1, span));
        end
        return it;
    endfunction

    // Pick two nodes whose walks only touch loaded entries; fall back to a
    // same-node query, which reads nothing.
    function automatic item_t random_query();
        item_t       it;
        logic [63:0] raw;
        result_t     r;
        bit          miss;
        raw = {$urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.mode = MODE_QUERY;
        if ($urandom_range(0, 99) < 8)
        begin
            it.node_b = it.node_a;
            return it;
        end
        for (int tries = 0; tries < 40; tries++)
        begin
            it.node_a = pick_node();
            if ($urandom_range(0, 1) == 1 && it.node_a >= NODE_W'(8))
                it.node_b = it.node_a - NODE_W'($urandom_range(1, 8));
            else
                it.node_b = pick_node();
            r = tree_distance(it.node_a, it.node_b, miss);
            if (!miss)
                return it;
        end
        it.node_b = it.node_a;
        return it;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_dist.size() == 0)
                note_error($sformatf("unexpected result: distance=%0d found=%0b",
                                     result.distance, result.found));
            else
            begin
                want = pending_dist.pop_front();
                if (result.distance !== want.distance)
                    note_error($sformatf("distance: expected %0d, got %0d",
                                         want.distance, result.distance));
                if (result.found !== want.found)
                    note_error($sformatf("found: expected %0b, got %0b",
                                         want.found, result.found));
            end
        end
    end

    initial
    begin
        item_t     it;
        result_t   typed_res;
        result_t   no_result;
        stim_row_t row;
        int        cycles;
        no_result = '0;
        foreach (parent_tbl[i])
            parent_tbl[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < N_ROWS; n++)
        begin
            row = DIRECTED_ROWS[n];
            it.mode          = row.mode;
            it.entry_index   = row.index;
            it.entry_parent  = row.parent;
            it.entry_is_root = row.is_root;
            it.node_a        = row.a;
            it.node_b        = row.b;
            typed_res.distance = row.exp_dist;
            typed_res.found    = row.found;
            send_item(it, row.typed, typed_res);
        end
        drain_results();

        next_new = 8;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            idle_pct = PHASE_IDLE_PCT[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 35)
                    it = random_load();
                else
                    it = random_query();
                send_item(it, CHECK_MODEL, no_result);
            end
            // hold off the sender until every pending result is back
            if (ph < N_PHASES - 1)
                drain_results();
        end

        start <= 1'b0;
        cycles = 0;
        while (pending_dist.size() != 0 && cycles < END_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (64) @(posedge clk);
        if (pending_dist.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_dist.size()));

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
